### design/gerh_pkg.sv
// Shared constants, codes and handshake types of the gray/edge region histogram unit.
`default_nettype none

package gerh_pkg;

    // Sizes
    localparam int BIN_COUNT  = 16;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // Field widths
    localparam int PIX_W       = 8;
    localparam int GRAY_W      = 8;
    localparam int GRAY_LEVELS = 256;
    localparam int SUM_W       = 10;
    localparam int CNT_W       = 21;
    localparam int BIN_IDX_W   = 6;
    localparam int CFG_W       = 11;
    localparam int THR_W       = 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Divide by three: floor(s/3) == (s*683) >> 11 for every s up to 765
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = SUM_W + 10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH    = 11'd256;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = 11'd256;
    localparam logic [THR_W-1:0] RST_EDGE_THRESHOLD = 8'd32;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic gray_en;
        logic eval_en;
        logic bump_en;
        logic emit_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic frame_end;
        logic slot_free;
        logic emit_last;
    } t_status;

endpackage

`default_nettype wire

### design/gray_edge_region_histogram_unit.sv
// Top level of the gray/edge region histogram unit: controller and datapath.
//
//  channel   direction  handshake                      payload (lowest bit up)
//  pixel     in         i_s_axis_tvalid/o_s_axis_tready  red[7:0] green[15:8] blue[23:16]
//  bin       out        o_m_axis_tvalid/i_m_axis_tready  bin_index, all, edge, top, bottom
//  config    in         i_cfg_we                        i_cfg_index, i_cfg_data
//
// Each pixel passes these steps in turn: accept with line store read, divide by three,
// edge and region test with line store write, histogram read-modify-write.
// After the last pixel of a frame one bin leaves per cycle while the output
// register drains; each bin is cleared as it leaves.
// Reset is synchronous and active low and clears position, histograms and
// configuration; the line store holds whatever it held. A stalled output only
// holds the unit while it still has bins of a finished frame to hand over.
`default_nettype none

module gray_edge_region_histogram_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // pixel request
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [23:0]                     i_s_axis_tdata,  // red, green, blue
    // bin result
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // bin_index[5:0], all_count[26:6], edge_count[47:27], top_count[68:48],
    // bottom_count[89:69], zero fill[95:90]
    output logic [95:0]                          o_m_axis_tdata,
    output logic                                 o_m_axis_tlast,  // last_bin
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [gerh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gerh_pkg::CFG_W-1:0]      i_cfg_data
);

    gerh_pkg::t_cmd    cmd;
    gerh_pkg::t_status status;

    logic [gerh_pkg::BIN_IDX_W-1:0] bin_index;
    logic [gerh_pkg::CNT_W-1:0]     all_count, edge_count, top_count, bottom_count;

    // Controller: one request at a time, then the bin readout
    gerh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_s_axis_tvalid),
        .o_pix_ready (o_s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: everything that holds or computes pixel data
    gerh_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_red          (i_s_axis_tdata[7:0]),
        .i_green        (i_s_axis_tdata[15:8]),
        .i_blue         (i_s_axis_tdata[23:16]),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_bin_index    (bin_index),
        .o_all_count    (all_count),
        .o_edge_count   (edge_count),
        .o_top_count    (top_count),
        .o_bottom_count (bottom_count),
        .o_last_bin     (o_m_axis_tlast)
    );

    // Pack the result fields, lowest field first, zero fill to whole bytes
    assign o_m_axis_tdata = {6'd0, bottom_count, top_count, edge_count, all_count, bin_index};

endmodule

`default_nettype wire

### design/gerh_ctrl.sv
// Sequencing state machine of the gray/edge region histogram unit.
`default_nettype none

module gerh_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_pix_valid,
    output logic                  o_pix_ready,
    input  wire gerh_pkg::t_status i_status,
    output gerh_pkg::t_cmd        o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_GRAY = 5'b00010,
        ST_EVAL = 5'b00100,
        ST_BUMP = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_pix_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pix_ready = 1'b1;
                if (i_pix_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_GRAY;
                end
            end
            ST_GRAY: begin
                o_cmd.gray_en = 1'b1;
                n_state       = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval_en = 1'b1;
                n_state       = ST_BUMP;
            end
            ST_BUMP: begin
                o_cmd.bump_en = 1'b1;
                n_state       = i_status.frame_end ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                // advance one bin whenever the output register can take it
                if (i_status.slot_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/gerh_datapath.sv
// Datapath: configuration, gray level, line store, edge test, histograms and output register.
`default_nettype none

module gerh_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire gerh_pkg::t_cmd                      i_cmd,
    output gerh_pkg::t_status                        o_status,
    input  wire logic                                i_cfg_we,
    input  wire logic [gerh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [gerh_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic [gerh_pkg::PIX_W-1:0]          i_red,
    input  wire logic [gerh_pkg::PIX_W-1:0]          i_green,
    input  wire logic [gerh_pkg::PIX_W-1:0]          i_blue,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [gerh_pkg::BIN_IDX_W-1:0]           o_bin_index,
    output logic [gerh_pkg::CNT_W-1:0]               o_all_count,
    output logic [gerh_pkg::CNT_W-1:0]               o_edge_count,
    output logic [gerh_pkg::CNT_W-1:0]               o_top_count,
    output logic [gerh_pkg::CNT_W-1:0]               o_bottom_count,
    output logic                                     o_last_bin
);

    localparam int MAX_SIZE = (gerh_pkg::MAX_WIDTH > gerh_pkg::MAX_HEIGHT) ?
                              gerh_pkg::MAX_WIDTH : gerh_pkg::MAX_HEIGHT;
    localparam int SZ_RAW   = $clog2(MAX_SIZE + 1);
    localparam int SZ_W     = ((SZ_RAW > gerh_pkg::CFG_W) ? SZ_RAW : gerh_pkg::CFG_W) + 1;
    localparam int REG_W    = SZ_W + 5;
    localparam int BP_W     = gerh_pkg::GRAY_W + $clog2(gerh_pkg::BIN_COUNT + 1);

    localparam logic [SZ_W-1:0] W_HI = SZ_W'(gerh_pkg::MAX_WIDTH);
    localparam logic [SZ_W-1:0] H_HI = SZ_W'(gerh_pkg::MAX_HEIGHT);

    function automatic logic [SZ_W-1:0] clamp_size(input logic [gerh_pkg::CFG_W-1:0] v,
                                                   input logic [SZ_W-1:0] hi);
        logic [SZ_W-1:0] ve;
        ve = SZ_W'(v);
        if (ve == '0) begin
            return SZ_W'(1);
        end else if (ve > hi) begin
            return hi;
        end
        return ve;
    endfunction

    function automatic logic [gerh_pkg::GRAY_W-1:0] abs_diff(
            input logic [gerh_pkg::GRAY_W-1:0] a, input logic [gerh_pkg::GRAY_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [gerh_pkg::CNT_W-1:0] sat_inc(input logic [gerh_pkg::CNT_W-1:0] c,
                                                           input logic en);
        return (en && (c != gerh_pkg::CNT_MAX)) ? (c + 1'b1) : c;
    endfunction

    function automatic logic [gerh_pkg::BIN_W-1:0] bin_sel_raw(input logic [BP_W-1:0] v);
        return v[gerh_pkg::BIN_W-1:0];
    endfunction

    // Configuration
    logic [gerh_pkg::CFG_W-1:0] r_frame_width;
    logic [gerh_pkg::CFG_W-1:0] r_frame_height;
    logic [gerh_pkg::THR_W-1:0] r_edge_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= gerh_pkg::RST_FRAME_WIDTH;
            r_frame_height   <= gerh_pkg::RST_FRAME_HEIGHT;
            r_edge_threshold <= gerh_pkg::RST_EDGE_THRESHOLD;
        end else if (i_cfg_we) begin
            if (i_cfg_index == gerh_pkg::CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data;
            end
            if (i_cfg_index == gerh_pkg::CFG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data;
            end
            if (i_cfg_index == gerh_pkg::CFG_EDGE_THRESHOLD) begin
                r_edge_threshold <= i_cfg_data[gerh_pkg::THR_W-1:0];
            end
        end
    end

    // Pixel sum, gray level and line store
    logic [gerh_pkg::SUM_W-1:0]  r_sum;
    logic [gerh_pkg::GRAY_W-1:0] r_gray;
    logic [gerh_pkg::GRAY_W-1:0] r_above;
    logic [gerh_pkg::GRAY_W-1:0] r_line [gerh_pkg::MAX_WIDTH];
    logic [gerh_pkg::COL_W-1:0]  r_col;
    logic [gerh_pkg::ROW_W-1:0]  r_row;
    logic [gerh_pkg::GRAY_W-1:0] r_left;
    logic [gerh_pkg::PROD_W-1:0] gray_prod;

    assign gray_prod = gerh_pkg::PROD_W'(r_sum) * gerh_pkg::PROD_W'(gerh_pkg::DIV3_MUL);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sum   <= gerh_pkg::SUM_W'(i_red) + gerh_pkg::SUM_W'(i_green)
                     + gerh_pkg::SUM_W'(i_blue);
            r_above <= r_line[r_col];
        end
        if (i_cmd.gray_en) begin
            r_gray <= gray_prod[gerh_pkg::DIV3_SHIFT +: gerh_pkg::GRAY_W];
        end
        if (i_cmd.eval_en) begin
            r_line[r_col] <= r_gray;
        end
    end

    // Evaluation of the pixel
    logic [SZ_W-1:0]             w_eff, h_eff;
    logic                        row_end, frame_end;
    logic [REG_W-1:0]            row_x20, row_x10, h_x9;
    logic [gerh_pkg::GRAY_W-1:0] d_left, d_above, d_max;
    logic                        is_edge;
    logic [BP_W-1:0]             bin_wide;
    logic [gerh_pkg::BIN_W-1:0]  bin_sel;

    assign w_eff     = clamp_size(r_frame_width, W_HI);
    assign h_eff     = clamp_size(r_frame_height, H_HI);
    assign row_end   = (SZ_W'(r_col) + SZ_W'(1)) >= w_eff;
    assign frame_end = row_end && ((SZ_W'(r_row) + SZ_W'(1)) >= h_eff);

    assign row_x20 = REG_W'(r_row) * REG_W'(20);
    assign row_x10 = REG_W'(r_row) * REG_W'(10);
    assign h_x9    = REG_W'(h_eff) * REG_W'(9);

    assign d_left  = abs_diff(r_gray, r_left);
    assign d_above = abs_diff(r_gray, r_above);
    assign d_max   = ((r_row != '0) && (d_above > d_left)) ? d_above : d_left;
    assign is_edge = (r_col != '0) && (d_max > r_edge_threshold);

    assign bin_wide = (BP_W'(r_gray) * BP_W'(gerh_pkg::BIN_COUNT))
                    / BP_W'(gerh_pkg::GRAY_LEVELS);
    assign bin_sel  = (bin_wide >= BP_W'(gerh_pkg::BIN_COUNT)) ?
                      gerh_pkg::BIN_W'(gerh_pkg::BIN_COUNT - 1) : bin_sel_raw(bin_wide);

    logic [gerh_pkg::BIN_W-1:0] r_bin;
    logic                       r_top, r_bottom, r_edge, r_frame_end;

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_en) begin
            r_bin    <= bin_sel;
            r_top    <= row_x20 < REG_W'(h_eff);
            r_bottom <= row_x10 > h_x9;
            r_edge   <= is_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_frame_end <= 1'b0;
        end else if (i_cmd.eval_en) begin
            r_frame_end <= frame_end;
            r_left      <= frame_end ? '0 : r_gray;
            if (!row_end) begin
                r_col <= r_col + 1'b1;
            end else begin
                r_col <= '0;
                r_row <= frame_end ? '0 : (r_row + 1'b1);
            end
        end
    end

    // Histograms, one read/write address shared by update and readout
    logic [gerh_pkg::CNT_W-1:0] r_all_hist    [gerh_pkg::BIN_COUNT];
    logic [gerh_pkg::CNT_W-1:0] r_edge_hist   [gerh_pkg::BIN_COUNT];
    logic [gerh_pkg::CNT_W-1:0] r_top_hist    [gerh_pkg::BIN_COUNT];
    logic [gerh_pkg::CNT_W-1:0] r_bottom_hist [gerh_pkg::BIN_COUNT];
    logic [gerh_pkg::BIN_W-1:0] r_k;
    logic [gerh_pkg::BIN_W-1:0] hist_addr;
    logic                       k_last;

    assign hist_addr = i_cmd.emit_load ? r_k : r_bin;
    assign k_last    = (r_k == gerh_pkg::BIN_W'(gerh_pkg::BIN_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gerh_pkg::BIN_COUNT; i++) begin
                r_all_hist[i]    <= '0;
                r_edge_hist[i]   <= '0;
                r_top_hist[i]    <= '0;
                r_bottom_hist[i] <= '0;
            end
        end else if (i_cmd.bump_en) begin
            r_all_hist[hist_addr]    <= sat_inc(r_all_hist[hist_addr], 1'b1);
            r_edge_hist[hist_addr]   <= sat_inc(r_edge_hist[hist_addr], r_edge);
            r_top_hist[hist_addr]    <= sat_inc(r_top_hist[hist_addr], r_top);
            r_bottom_hist[hist_addr] <= sat_inc(r_bottom_hist[hist_addr], r_bottom);
        end else if (i_cmd.emit_load) begin
            // drop the bin once it has moved to the output register
            r_all_hist[hist_addr]    <= '0;
            r_edge_hist[hist_addr]   <= '0;
            r_top_hist[hist_addr]    <= '0;
            r_bottom_hist[hist_addr] <= '0;
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
                r_k         <= k_last ? '0 : (r_k + 1'b1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_bin_index    <= gerh_pkg::BIN_IDX_W'(r_k);
            o_all_count    <= r_all_hist[hist_addr];
            o_edge_count   <= r_edge_hist[hist_addr];
            o_top_count    <= r_top_hist[hist_addr];
            o_bottom_count <= r_bottom_hist[hist_addr];
            o_last_bin     <= k_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status.frame_end = r_frame_end;
    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_status.emit_last = k_last;

endmodule

`default_nettype wire
